// ===== rtl/gpwr_pkg.sv =====
// ============================================================================
// gpwr_pkg : mirror ghost wall reflection, shared types and constants
// Field widths, internal stage payloads, wall codes and register indexes.
// ============================================================================
package gpwr_pkg;

    // field widths
    localparam int CFG_W  = 30;   // config registers, unsigned
    localparam int POS_W  = 31;   // input position
    localparam int VEL_W  = 31;   // input velocity
    localparam int P_W    = 32;   // pressure
    localparam int CMP_W  = 32;   // band limits and compares
    localparam int EXT_W  = 34;   // mirrored position before saturation
    localparam int VN_W   = 32;   // (possibly negated) velocity
    localparam int SUM_W  = 33;   // normal velocity sums
    localparam int K_W    = 25;   // 1/sqrt(2) constant, signed, positive
    localparam int PROD_W = 58;   // diagonal product
    localparam int IDX_W  = 2;    // ghost index within one particle

    // 2^32 / sqrt(2), scaled down to the fraction width at elaboration
    localparam logic [63:0] SQRT_HALF_Q32 = 64'd3037000500;

    // APB
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_HALF_WIDTH      = 2'd0;
    localparam logic [1:0] REG_HALF_HEIGHT     = 2'd1;
    localparam logic [1:0] REG_LAYER_THICKNESS = 2'd2;
    localparam logic [1:0] REG_APPROACH_MARGIN = 2'd3;

    // register reset values
    localparam logic [CFG_W-1:0] RST_HALF_WIDTH      = 30'd32768;
    localparam logic [CFG_W-1:0] RST_HALF_HEIGHT     = 30'd32768;
    localparam logic [CFG_W-1:0] RST_LAYER_THICKNESS = 30'd13107;
    localparam logic [CFG_W-1:0] RST_APPROACH_MARGIN = 30'd66;

    // mirror wall codes
    localparam logic [2:0] WALL_E  = 3'd0;
    localparam logic [2:0] WALL_W  = 3'd1;
    localparam logic [2:0] WALL_N  = 3'd2;
    localparam logic [2:0] WALL_S  = 3'd3;
    localparam logic [2:0] WALL_NE = 3'd4;
    localparam logic [2:0] WALL_SE = 3'd5;
    localparam logic [2:0] WALL_NW = 3'd6;
    localparam logic [2:0] WALL_SW = 3'd7;

    typedef struct packed {
        logic [CFG_W-1:0] half_width;
        logic [CFG_W-1:0] half_height;
        logic [CFG_W-1:0] layer_thickness;
        logic [CFG_W-1:0] approach_margin;
    } gpwr_cfg_t;

    // after band classification
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [P_W-1:0]   p;
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        logic                    east;
        logic                    west;
        logic                    north;
        logic                    south;
    } gpwr_part_t;

    // after mirroring and axis approach tests
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [P_W-1:0]   p;
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        logic signed [EXT_W-1:0] xm;
        logic signed [EXT_W-1:0] ym;
        logic                    east;
        logic                    north;
        logic                    corner;
        logic                    xside;
        logic                    x_zero;
        logic                    y_zero;
        logic signed [SUM_W-1:0] s;
    } gpwr_refl_t;

    typedef struct packed {
        logic signed [EXT_W-1:0] gx;
        logic signed [EXT_W-1:0] gy;
        logic signed [VN_W-1:0]  vx;
        logic signed [VN_W-1:0]  vy;
        logic [2:0]              wall;
    } gpwr_ghost_t;

    // one particle's ghosts, ready for serialization
    typedef struct packed {
        gpwr_ghost_t [2:0]       ghost;
        logic signed [P_W-1:0]   p;
        logic [IDX_W-1:0]        last_idx;
    } gpwr_item_t;

endpackage

// ===== rtl/gpwr_cfg_regs.sv =====
// ============================================================================
// gpwr_cfg_regs : APB register file
// Four 30 bit box registers at byte addresses 0, 4, 8, 12.
// ============================================================================
module gpwr_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gpwr_pkg::ADDR_W-1:0]   paddr,
    input  logic [gpwr_pkg::DATA_W-1:0]   pwdata,
    output logic [gpwr_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output gpwr_pkg::gpwr_cfg_t           cfg
);

    gpwr_pkg::gpwr_cfg_t cfg_reg;
    logic [1:0]          reg_idx;
    logic                wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_width      <= gpwr_pkg::RST_HALF_WIDTH;
            cfg_reg.half_height     <= gpwr_pkg::RST_HALF_HEIGHT;
            cfg_reg.layer_thickness <= gpwr_pkg::RST_LAYER_THICKNESS;
            cfg_reg.approach_margin <= gpwr_pkg::RST_APPROACH_MARGIN;
        end else if (wr_en) begin
            case (reg_idx)
                gpwr_pkg::REG_HALF_WIDTH:
                    cfg_reg.half_width <= pwdata[gpwr_pkg::CFG_W-1:0];
                gpwr_pkg::REG_HALF_HEIGHT:
                    cfg_reg.half_height <= pwdata[gpwr_pkg::CFG_W-1:0];
                gpwr_pkg::REG_LAYER_THICKNESS:
                    cfg_reg.layer_thickness <= pwdata[gpwr_pkg::CFG_W-1:0];
                gpwr_pkg::REG_APPROACH_MARGIN:
                    cfg_reg.approach_margin <= pwdata[gpwr_pkg::CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            gpwr_pkg::REG_HALF_WIDTH:      prdata = {2'b00, cfg_reg.half_width};
            gpwr_pkg::REG_HALF_HEIGHT:     prdata = {2'b00, cfg_reg.half_height};
            gpwr_pkg::REG_LAYER_THICKNESS: prdata = {2'b00, cfg_reg.layer_thickness};
            gpwr_pkg::REG_APPROACH_MARGIN: prdata = {2'b00, cfg_reg.approach_margin};
            default:                       prdata = '0;
        endcase
    end

endmodule

// ===== rtl/gpwr_classify.sv =====
// ============================================================================
// gpwr_classify : stage 1, band classification
// Drops particles inside the inner box or outside the outer box.
// ============================================================================
module gpwr_classify (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  gpwr_pkg::gpwr_cfg_t                  cfg,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [gpwr_pkg::POS_W-1:0]    pos_x,
    input  logic signed [gpwr_pkg::POS_W-1:0]    pos_y,
    input  logic signed [gpwr_pkg::P_W-1:0]      pressure_in,
    input  logic signed [gpwr_pkg::VEL_W-1:0]    vel_x,
    input  logic signed [gpwr_pkg::VEL_W-1:0]    vel_y,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output gpwr_pkg::gpwr_part_t                 out_data
);

    logic signed [gpwr_pkg::CMP_W-1:0] xe, ye, w_ext, h_ext, l_ext;
    logic signed [gpwr_pkg::CMP_W-1:0] rb, lb, nb, sb;
    logic                              in_core, outside, keep;
    gpwr_pkg::gpwr_part_t              part_next;
    gpwr_pkg::gpwr_part_t              part_reg;
    logic                              valid_reg;

    always_comb begin
        xe    = {pos_x[gpwr_pkg::POS_W-1], pos_x};
        ye    = {pos_y[gpwr_pkg::POS_W-1], pos_y};
        w_ext = {2'b00, cfg.half_width};
        h_ext = {2'b00, cfg.half_height};
        l_ext = {2'b00, cfg.layer_thickness};
        rb    = w_ext - l_ext;
        lb    = -rb;
        nb    = h_ext - l_ext;
        sb    = -nb;

        in_core = (xe < rb) && (xe > lb) && (ye < nb) && (ye > sb);
        outside = (xe > w_ext) || (xe < -w_ext) || (ye > h_ext) || (ye < -h_ext);
        keep    = !in_core && !outside;

        part_next.x     = pos_x;
        part_next.y     = pos_y;
        part_next.p     = pressure_in;
        part_next.vx    = vel_x;
        part_next.vy    = vel_y;
        part_next.east  = (xe >= rb);
        part_next.west  = !(xe >= rb) && (xe <= lb);
        part_next.north = (ye >= nb);
        part_next.south = !(ye >= nb) && (ye <= sb);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = part_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid && keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            part_reg <= part_next;
        end
    end

endmodule

// ===== rtl/gpwr_reflect.sv =====
// ============================================================================
// gpwr_reflect : stage 2, mirror positions and axis approach tests
// Also forms the outward diagonal velocity sum for the next stage.
// ============================================================================
module gpwr_reflect (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gpwr_pkg::gpwr_cfg_t   cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  gpwr_pkg::gpwr_part_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output gpwr_pkg::gpwr_refl_t  out_data
);

    logic signed [gpwr_pkg::EXT_W-1:0] w2, h2, xe, ye;
    logic signed [gpwr_pkg::SUM_W-1:0] vxe, vye, xn, yn, e_ext, xt, yt;
    gpwr_pkg::gpwr_refl_t              refl_next;
    gpwr_pkg::gpwr_refl_t              refl_reg;
    logic                              valid_reg;

    always_comb begin
        w2    = {3'b000, cfg.half_width, 1'b0};
        h2    = {3'b000, cfg.half_height, 1'b0};
        xe    = {{3{in_data.x[gpwr_pkg::POS_W-1]}}, in_data.x};
        ye    = {{3{in_data.y[gpwr_pkg::POS_W-1]}}, in_data.y};
        vxe   = {{2{in_data.vx[gpwr_pkg::VEL_W-1]}}, in_data.vx};
        vye   = {{2{in_data.vy[gpwr_pkg::VEL_W-1]}}, in_data.vy};
        e_ext = {3'b000, cfg.approach_margin};

        // outward normal components
        xn = in_data.east  ? vxe : -vxe;
        yn = in_data.north ? vye : -vye;
        xt = xn + e_ext;
        yt = yn + e_ext;

        refl_next.x      = in_data.x;
        refl_next.y      = in_data.y;
        refl_next.p      = in_data.p;
        refl_next.vx     = in_data.vx;
        refl_next.vy     = in_data.vy;
        refl_next.xm     = in_data.east  ? (w2 - xe) : (-w2 - xe);
        refl_next.ym     = in_data.north ? (h2 - ye) : (-h2 - ye);
        refl_next.east   = in_data.east;
        refl_next.north  = in_data.north;
        refl_next.xside  = in_data.east || in_data.west;
        refl_next.corner = (in_data.east || in_data.west) &&
                           (in_data.north || in_data.south);
        refl_next.x_zero = (xt <= 0);
        refl_next.y_zero = (yt <= 0);
        refl_next.s      = xn + yn;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = refl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            refl_reg <= refl_next;
        end
    end

endmodule

// ===== rtl/gpwr_diag.sv =====
// ============================================================================
// gpwr_diag : stages 3 and 4, diagonal test and ghost assembly
// Stage 3 multiplies the diagonal sum by 1/sqrt(2); stage 4 floors,
// tests against the margin and builds the ghost set of one particle.
// ============================================================================
module gpwr_diag #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gpwr_pkg::gpwr_cfg_t   cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  gpwr_pkg::gpwr_refl_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output gpwr_pkg::gpwr_item_t  out_data
);

    localparam logic [63:0] K_FULL =
        (gpwr_pkg::SQRT_HALF_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic signed [gpwr_pkg::K_W-1:0] K_VAL = gpwr_pkg::K_W'(K_FULL);

    // stage 3
    logic signed [gpwr_pkg::PROD_W-1:0] s_ext, k_ext, prod_next;
    gpwr_pkg::gpwr_refl_t               refl_reg;
    logic signed [gpwr_pkg::PROD_W-1:0] prod_reg;
    logic                               a_valid_reg;
    logic                               a_ready;

    // stage 4
    logic signed [gpwr_pkg::PROD_W-1:0] ip;
    logic signed [gpwr_pkg::PROD_W:0]   dsum;
    logic                               d_zero;
    logic signed [gpwr_pkg::VN_W-1:0]   vxw, vyw;
    gpwr_pkg::gpwr_ghost_t              xg, yg, dg;
    gpwr_pkg::gpwr_item_t               item_next;
    gpwr_pkg::gpwr_item_t               item_reg;
    logic                               b_valid_reg;
    logic                               b_ready;

    assign s_ext = $signed({{(gpwr_pkg::PROD_W - gpwr_pkg::SUM_W){in_data.s[gpwr_pkg::SUM_W-1]}},
                            in_data.s});
    assign k_ext = $signed({{(gpwr_pkg::PROD_W - gpwr_pkg::K_W){1'b0}}, K_VAL});
    assign prod_next = s_ext * k_ext;

    assign b_ready   = !b_valid_reg || out_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign in_ready  = a_ready;
    assign out_valid = b_valid_reg;
    assign out_data  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && a_ready) begin
            refl_reg <= in_data;
            prod_reg <= prod_next;
        end
        if (a_valid_reg && b_ready) begin
            item_reg <= item_next;
        end
    end

    always_comb begin
        // arithmetic shift floors negative products
        ip     = prod_reg >>> FRAC_BITS;
        dsum   = {ip[gpwr_pkg::PROD_W-1], ip} +
                 {{(gpwr_pkg::PROD_W + 1 - gpwr_pkg::CFG_W){1'b0}}, cfg.approach_margin};
        d_zero = (dsum <= 0);

        vxw = {refl_reg.vx[gpwr_pkg::VEL_W-1], refl_reg.vx};
        vyw = {refl_reg.vy[gpwr_pkg::VEL_W-1], refl_reg.vy};

        // x wall ghost
        xg.gx   = refl_reg.xm;
        xg.gy   = {{3{refl_reg.y[gpwr_pkg::POS_W-1]}}, refl_reg.y};
        xg.vx   = refl_reg.x_zero ? '0 : -vxw;
        xg.vy   = refl_reg.x_zero ? '0 : vyw;
        xg.wall = refl_reg.east ? gpwr_pkg::WALL_E : gpwr_pkg::WALL_W;

        // y wall ghost
        yg.gx   = {{3{refl_reg.x[gpwr_pkg::POS_W-1]}}, refl_reg.x};
        yg.gy   = refl_reg.ym;
        yg.vx   = refl_reg.y_zero ? '0 : vxw;
        yg.vy   = refl_reg.y_zero ? '0 : -vyw;
        yg.wall = refl_reg.north ? gpwr_pkg::WALL_N : gpwr_pkg::WALL_S;

        // diagonal ghost: swap and negate when the normal signs agree
        dg.gx = refl_reg.xm;
        dg.gy = refl_reg.ym;
        if (d_zero) begin
            dg.vx = '0;
            dg.vy = '0;
        end else if (refl_reg.east == refl_reg.north) begin
            dg.vx = -vyw;
            dg.vy = -vxw;
        end else begin
            dg.vx = vyw;
            dg.vy = vxw;
        end
        if (refl_reg.east) begin
            dg.wall = refl_reg.north ? gpwr_pkg::WALL_NE : gpwr_pkg::WALL_SE;
        end else begin
            dg.wall = refl_reg.north ? gpwr_pkg::WALL_NW : gpwr_pkg::WALL_SW;
        end

        item_next.p = refl_reg.p;
        if (refl_reg.corner) begin
            item_next.ghost    = {dg, yg, xg};
            item_next.last_idx = 2'd2;
        end else if (refl_reg.xside) begin
            item_next.ghost    = {xg, xg, xg};
            item_next.last_idx = 2'd0;
        end else begin
            item_next.ghost    = {yg, yg, yg};
            item_next.last_idx = 2'd0;
        end
    end

endmodule

// ===== rtl/gpwr_serializer.sv =====
// ============================================================================
// gpwr_serializer : output stage
// Holds one particle's ghosts and sends them one beat each, saturated.
// ============================================================================
module gpwr_serializer #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  gpwr_pkg::gpwr_item_t    in_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [VALUE_WIDTH-1:0]  m_ghost_x,
    output logic [VALUE_WIDTH-1:0]  m_ghost_y,
    output logic [VALUE_WIDTH-1:0]  m_ghost_pressure,
    output logic [VALUE_WIDTH-1:0]  m_ghost_vx,
    output logic [VALUE_WIDTH-1:0]  m_ghost_vy,
    output logic [2:0]              m_mirror_wall,
    output logic                    m_last_ghost
);

    localparam int CW = ((VALUE_WIDTH > gpwr_pkg::EXT_W) ? VALUE_WIDTH : gpwr_pkg::EXT_W) + 1;
    localparam logic signed [CW-1:0] LIM =
        {{(CW - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};

    gpwr_pkg::gpwr_item_t            item_reg;
    logic                            valid_reg;
    logic [gpwr_pkg::IDX_W-1:0]      idx_reg;
    gpwr_pkg::gpwr_ghost_t           g;
    logic                            last;

    function automatic logic [VALUE_WIDTH-1:0] sat(input logic signed [gpwr_pkg::EXT_W-1:0] v);
        logic signed [CW-1:0] ve;
        logic signed [CW-1:0] r;
        ve = CW'(v);
        if (ve > LIM) begin
            r = LIM;
        end else if (ve < -LIM) begin
            r = -LIM;
        end else begin
            r = ve;
        end
        return r[VALUE_WIDTH-1:0];
    endfunction

    always_comb begin
        case (idx_reg)
            2'd0:    g = item_reg.ghost[0];
            2'd1:    g = item_reg.ghost[1];
            default: g = item_reg.ghost[2];
        endcase
    end

    assign last     = (idx_reg == item_reg.last_idx);
    assign in_ready = !valid_reg || (m_ready && last);
    assign m_valid  = valid_reg;

    assign m_ghost_x        = sat(g.gx);
    assign m_ghost_y        = sat(g.gy);
    assign m_ghost_pressure = sat($signed({{2{item_reg.p[gpwr_pkg::P_W-1]}}, item_reg.p}));
    assign m_ghost_vx       = sat($signed({{2{g.vx[gpwr_pkg::VN_W-1]}}, g.vx}));
    assign m_ghost_vy       = sat($signed({{2{g.vy[gpwr_pkg::VN_W-1]}}, g.vy}));
    assign m_mirror_wall    = g.wall;
    assign m_last_ghost     = last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
            idx_reg   <= '0;
        end else if (m_ready) begin
            idx_reg   <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_data;
        end
    end

endmodule

// ===== rtl/ghost_particle_wall_reflect_top.sv =====
// ============================================================================
// ghost_particle_wall_reflect_top : mirror ghost generator for a 2D box
// Emits 0, 1 or 3 mirrored ghost beats per particle, Q16.16 fixed point.
// ============================================================================
//
//  channel  dir  handshake         payload
//  -------  ---  ----------------  --------------------------------------------
//  s_       in   s_valid/s_ready   pos_x, pos_y, pressure_in, vel_x, vel_y
//  m_       out  m_valid/m_ready   ghost_x/y, pressure, vx/vy, wall, last_ghost
//  apb      in   psel/penable      four 30 bit box registers, pready tied high
//
//  Path: stage 1, stage 2, stages 3 and 4, then the output register.
//  Throughput: a particle every cycle when each makes one ghost and m_ready
//  is high; a corner particle holds the single result port for three beats.
//  Particles that make no ghost are dropped in stage 1.
//  Reset (aresetn low, synchronous) empties the pipe and loads register defaults.
//  A stall on m_ready backs up stage by stage; nothing is lost or repeated.
//
module ghost_particle_wall_reflect_top #(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // APB register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gpwr_pkg::ADDR_W-1:0]         paddr,
    input  logic [gpwr_pkg::DATA_W-1:0]         pwdata,
    output logic [gpwr_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,

    // particle input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [gpwr_pkg::POS_W-1:0]   s_pos_x,
    input  logic signed [gpwr_pkg::POS_W-1:0]   s_pos_y,
    input  logic signed [gpwr_pkg::P_W-1:0]     s_pressure_in,
    input  logic signed [gpwr_pkg::VEL_W-1:0]   s_vel_x,
    input  logic signed [gpwr_pkg::VEL_W-1:0]   s_vel_y,

    // ghost output
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [VALUE_WIDTH-1:0]              m_ghost_x,
    output logic [VALUE_WIDTH-1:0]              m_ghost_y,
    output logic [VALUE_WIDTH-1:0]              m_ghost_pressure,
    output logic [VALUE_WIDTH-1:0]              m_ghost_vx,
    output logic [VALUE_WIDTH-1:0]              m_ghost_vy,
    output logic [2:0]                          m_mirror_wall,
    output logic                                m_last_ghost
);

    gpwr_pkg::gpwr_cfg_t   cfg;

    // stage 1 -> stage 2
    logic                  c_valid, c_ready;
    gpwr_pkg::gpwr_part_t  c_data;

    // stage 2 -> stages 3/4
    logic                  r_valid, r_ready;
    gpwr_pkg::gpwr_refl_t  r_data;

    // stage 4 -> output
    logic                  d_valid, d_ready;
    gpwr_pkg::gpwr_item_t  d_data;

    // the user must see that registers only change while the pipe is empty; the block itself does not enforce it
    gpwr_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // stage 1: inner/outer box tests, band flags
    gpwr_classify u_classify (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .pos_x       (s_pos_x),
        .pos_y       (s_pos_y),
        .pressure_in (s_pressure_in),
        .vel_x       (s_vel_x),
        .vel_y       (s_vel_y),
        .out_valid   (c_valid),
        .out_ready   (c_ready),
        .out_data    (c_data)
    );

    // stage 2: mirrored positions, axis approach tests, diagonal sum
    gpwr_reflect u_reflect (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .in_data   (c_data),
        .out_valid (r_valid),
        .out_ready (r_ready),
        .out_data  (r_data)
    );

    // stages 3 and 4: 1/sqrt(2) product, diagonal test, ghost set
    gpwr_diag #(
        .FRAC_BITS (FRAC_BITS)
    ) u_diag (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (r_valid),
        .in_ready  (r_ready),
        .in_data   (r_data),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_data  (d_data)
    );

    // output register: one beat per ghost, saturation on the way out
    gpwr_serializer #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ser (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (d_valid),
        .in_ready         (d_ready),
        .in_data          (d_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_ghost_x        (m_ghost_x),
        .m_ghost_y        (m_ghost_y),
        .m_ghost_pressure (m_ghost_pressure),
        .m_ghost_vx       (m_ghost_vx),
        .m_ghost_vy       (m_ghost_vy),
        .m_mirror_wall    (m_mirror_wall),
        .m_last_ghost     (m_last_ghost)
    );

endmodule
